// ----- hdl/tsmt_pkg.sv -----
// Shared types and codes for the timed square mark table.
package tsmt_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int MAX_OUT      = 64;
	localparam int NREM_W       = $clog2(MAX_OUT);
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 16;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_SWEEP = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [3:0] ST_REFRESHED = 4'd0;
	localparam logic [3:0] ST_CREATED   = 4'd1;
	localparam logic [3:0] ST_PRESENT   = 4'd2;
	localparam logic [3:0] ST_ABSENT    = 4'd3;
	localparam logic [3:0] ST_REMOVED   = 4'd4;
	localparam logic [3:0] ST_REJECTED  = 4'd5;
	localparam logic [3:0] ST_FULL      = 4'd6;
	localparam logic [3:0] ST_DONE      = 4'd7;
	localparam logic [3:0] ST_CLEARED   = 4'd8;

	localparam logic [CFG_IDX_W-1:0] REG_ROOM_COUNT   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOM_WIDTH   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROOM_HEIGHT  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINGER_TICKS = 8'd3;

	typedef struct packed {
		logic        valid;
		logic [9:0]  room;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [31:0] expiry;
	} slot_t;

	// Load and shift controls shared by every cell of the ring
	typedef struct packed {
		logic  shift;
		logic  clr;
		slot_t wdata;
	} cell_ctl_t;

endpackage

// ----- hdl/tsmt_intf.sv -----
// Channel interfaces: request words, result words and register writes.
interface tsmt_req_if import tsmt_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [9:0]  room;
	logic [7:0]  x;
	logic [7:0]  y;
	logic [31:0] current_time;

	modport source(output valid, command, room, x, y, current_time, input ready);
	modport sink(input valid, command, room, x, y, current_time, output ready);
endinterface

interface tsmt_rsp_if import tsmt_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [9:0]  room_res;
	logic [7:0]  x_res;
	logic [7:0]  y_res;
	logic        last;

	modport source(output valid, status, room_res, x_res, y_res, last, input ready);
	modport sink(input valid, status, room_res, x_res, y_res, last, output ready);
endinterface

interface tsmt_cfg_if import tsmt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/tsmt_cell.sv -----
// One slot of the mark ring: takes its neighbour's slot on shift, or a direct load.
module tsmt_cell import tsmt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      wr,
	input  slot_t     nb,
	output slot_t     slot
);

	logic        valid_q;
	logic [9:0]  room_q;
	logic [7:0]  col_q;
	logic [7:0]  row_q;
	logic [31:0] expiry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end else if (wr) begin
			valid_q <= ctl.wdata.valid;
		end else if (ctl.shift) begin
			valid_q <= nb.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			room_q   <= ctl.wdata.room;
			col_q    <= ctl.wdata.col;
			row_q    <= ctl.wdata.row;
			expiry_q <= ctl.wdata.expiry;
		end else if (ctl.shift) begin
			room_q   <= nb.room;
			col_q    <= nb.col;
			row_q    <= nb.row;
			expiry_q <= nb.expiry;
		end
	end

	assign slot = '{valid: valid_q, room: room_q, col: col_q, row: row_q, expiry: expiry_q};

endmodule

// ----- hdl/timed_square_mark_table.sv -----
// Timed square mark table: top level with the slot ring, scan control and result register.
//
// The table keeps CAPACITY marks, each a (room, x, y) key with an expiry time, in a ring
// of identical cells. While a word is worked on, the ring rotates by one cell per clock
// unless a sweep holds it, so the head cell shows slot 0, 1, 2 ... in turn and the control
// examines it there; a full turn brings every slot back to its home cell. Add and query
// take one turn to look for the key (and, for add, the lowest free slot), then a final
// step writes the chosen slot and loads the result; the next request word is taken once
// the block is idle again. A sweep takes the same turn, removing each expired mark as it
// passes the head and presenting it as a result; the turn pauses whenever a removal finds
// the result register full and the consumer not ready. A sweep removes at most MAX_OUT - 1
// marks; the rest stay for the next sweep. A rejected add and a clear need no turn and go
// straight to the final step. Any word waits in its final step until the result register
// can take its result. Only one word is worked on at a time; the result register lets the
// ring go on while a result waits.
// Register writes are taken at any time and must only be made while the block is idle.
// Reset empties the table at once; there is no clearing pass.
module timed_square_mark_table import tsmt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tsmt_req_if.sink   req,
	tsmt_rsp_if.source rsp,
	tsmt_cfg_if.sink   cfg
);

	localparam int IDX_W = $clog2(CAPACITY);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_RESULT = 2'd2;

	// configuration registers
	logic [9:0]  room_count_q;
	logic [7:0]  room_width_q;
	logic [7:0]  room_height_q;
	logic [15:0] linger_q;

	// word being worked on
	logic [1:0]  state_q;
	logic [1:0]  cmd_q;
	logic [9:0]  room_q;
	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic [31:0] now_q;
	logic [31:0] exp_q;
	logic        rej_q;

	// scan progress
	logic [IDX_W-1:0]  step_q;
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [NREM_W-1:0] nrem_q;

	// result register
	logic        out_valid_q;
	logic [3:0]  status_q;
	logic [9:0]  room_res_q;
	logic [7:0]  x_res_q;
	logic [7:0]  y_res_q;
	logic        last_q;

	// ring
	slot_t             cell_slot [CAPACITY];
	slot_t             ring_in   [CAPACITY];
	logic [CAPACITY-1:0] valid_vec;
	cell_ctl_t         ctl;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;

	logic        accept;
	logic        out_can_load;
	logic        out_load;
	logic [3:0]  ld_status;
	logic [9:0]  ld_room;
	logic [7:0]  ld_x;
	logic [7:0]  ld_y;
	logic        ld_last;
	slot_t       head;
	logic        key_match;
	logic        remove_now;
	logic        advance;
	logic        in_reject;
	logic [32:0] exp_sum;

	// ---------------------------------------------------------------- configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_count_q  <= 10'd0;
			room_width_q  <= 8'd20;
			room_height_q <= 8'd20;
			linger_q      <= 16'd100;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ROOM_COUNT:   room_count_q  <= cfg.data[9:0];
				REG_ROOM_WIDTH:   room_width_q  <= cfg.data[7:0];
				REG_ROOM_HEIGHT:  room_height_q <= cfg.data[7:0];
				REG_LINGER_TICKS: linger_q      <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- request side
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	// add range check; a query checks the room only, at the end of its turn
	assign in_reject = (req.room >= room_count_q) || (req.x >= room_width_q) ||
	                   (req.y >= room_height_q);

	// expiry = now + linger, held at the top of the time range
	assign exp_sum = {1'b0, req.current_time} + {17'd0, linger_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			room_q <= req.room;
			x_q    <= req.x;
			y_q    <= req.y;
			now_q  <= req.current_time;
			exp_q  <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
		end
	end

	// ---------------------------------------------------------------- head of the ring
	assign head      = cell_slot[0];
	assign key_match = head.valid && (head.room == room_q) && (head.col == x_q) &&
	                   (head.row == y_q);

	// drop an expired mark as it passes, while the sweep still has room for results
	assign remove_now = (state_q == S_SCAN) && (cmd_q == CMD_SWEEP) && head.valid &&
	                    (head.expiry <= now_q) && (nrem_q != NREM_W'(MAX_OUT - 1));

	assign out_can_load = !out_valid_q || rsp.ready;

	// hold the ring while a removal waits for the result register
	assign advance = (state_q == S_SCAN) && (!remove_now || out_can_load);

	// ---------------------------------------------------------------- result selection
	always_comb begin
		ld_status = ST_DONE;
		ld_room   = 10'd0;
		ld_x      = 8'd0;
		ld_y      = 8'd0;
		ld_last   = 1'b1;
		wr_en     = 1'b0;
		wr_idx    = free_idx_q;
		ctl.shift = advance;
		ctl.clr   = accept && (req.command == CMD_CLEAR);
		ctl.wdata = '{valid: 1'b1, room: room_q, col: x_q, row: y_q, expiry: exp_q};
		if (state_q == S_SCAN) begin
			ld_status = ST_REMOVED;
			ld_room   = head.room;
			ld_x      = head.col;
			ld_y      = head.row;
			ld_last   = 1'b0;
		end else begin
			case (cmd_q)
				CMD_ADD: begin
					ld_room = room_q;
					ld_x    = x_q;
					ld_y    = y_q;
					if (rej_q) begin
						ld_status = ST_REJECTED;
					end else if (hit_q) begin
						ld_status = ST_REFRESHED;
						wr_en     = 1'b1;
						wr_idx    = hit_idx_q;
					end else if (free_q) begin
						ld_status = ST_CREATED;
						wr_en     = 1'b1;
					end else begin
						ld_status = ST_FULL;
					end
				end
				CMD_QUERY: begin
					ld_room   = room_q;
					ld_x      = x_q;
					ld_y      = y_q;
					ld_status = (hit_q && (room_q < room_count_q)) ? ST_PRESENT : ST_ABSENT;
				end
				CMD_SWEEP: ld_status = ST_DONE;
				CMD_CLEAR: ld_status = ST_CLEARED;
				default:   ld_status = ST_DONE;
			endcase
		end
		wr_en = wr_en && (state_q == S_RESULT) && out_can_load;
	end

	assign out_load = ((state_q == S_SCAN) && remove_now && out_can_load) ||
	                  ((state_q == S_RESULT) && out_can_load);

	// ---------------------------------------------------------------- ring of cells
	// head goes round to the tail, emptied if it was removed on the way
	always_comb begin
		for (int k = 0; k < CAPACITY - 1; k++) begin
			ring_in[k] = cell_slot[k + 1];
		end
		ring_in[CAPACITY - 1]       = head;
		ring_in[CAPACITY - 1].valid = head.valid && !remove_now;
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		tsmt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.wr     (wr_en && (wr_idx == IDX_W'(k))),
			.nb     (ring_in[k]),
			.slot   (cell_slot[k])
		);
		assign valid_vec[k] = cell_slot[k].valid;
	end

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rej_q      <= 1'b0;
			step_q     <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			nrem_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						nrem_q <= '0;
						rej_q  <= (req.command == CMD_ADD) && in_reject;
						if ((req.command == CMD_CLEAR) ||
						    ((req.command == CMD_ADD) && in_reject)) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (advance) begin
						if (key_match && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= step_q;
						end
						if (!head.valid && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= step_q;
						end
						if (remove_now) begin
							nrem_q <= nrem_q + 1'b1;
						end
						if (step_q == IDX_W'(CAPACITY - 1)) begin
							step_q  <= '0;
							state_q <= S_RESULT;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				S_RESULT: begin
					if (out_can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q   <= ld_status;
			room_res_q <= ld_room;
			x_res_q    <= ld_x;
			y_res_q    <= ld_y;
			last_q     <= ld_last;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = status_q;
	assign rsp.room_res = room_res_q;
	assign rsp.x_res    = x_res_q;
	assign rsp.y_res    = y_res_q;
	assign rsp.last     = last_q;

	// ---------------------------------------------------------------- checks
	// a clear empties every slot in the very next cycle
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.command == CMD_CLEAR)) |=> (valid_vec == '0))
		else $error("table not empty after clear");

	// the ring is back at its home position whenever the block is idle
	a_ring_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (step_q == '0))
		else $error("ring left out of alignment");

	// the final result of a word ends its work
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && ld_last) |=> (state_q == S_IDLE))
		else $error("work continues after final result");

	// the ring never turns while a request may be taken
	a_idle_still: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !ctl.shift)
		else $error("ring shifts while idle");

endmodule

// ----- verif/tb_timed_square_mark_table.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the timed square mark table: predictor, directed and random tests.
module tb_timed_square_mark_table;
	import tsmt_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int RESET_TICKS = 8;
	localparam int MAX_REPORTS = 10;
	// Slowest add or query is a full ring turn and its final step; allow a margin on top
	localparam int SETTLE_TICKS = CAPACITY_DEF + 8;

	// One result word as the checker sees it
	typedef struct packed {
		logic [3:0] status;
		logic [9:0] room;
		logic [7:0] x;
		logic [7:0] y;
		logic       last;
	} mark_result_t;

	logic clk;
	logic arst_n;

	tsmt_req_if req_ch();
	tsmt_rsp_if rsp_ch();
	tsmt_cfg_if cfg_ch();

	timed_square_mark_table #(
		.CAPACITY(CAPACITY_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// Private copy of the table and its registers, advanced on every accepted word
	logic        mark_valid  [CAPACITY_DEF];
	logic [9:0]  mark_room   [CAPACITY_DEF];
	logic [7:0]  mark_col    [CAPACITY_DEF];
	logic [7:0]  mark_row    [CAPACITY_DEF];
	logic [31:0] mark_expiry [CAPACITY_DEF];
	logic [9:0]  cur_room_count;
	logic [7:0]  cur_width;
	logic [7:0]  cur_height;
	logic [15:0] cur_linger;

	mark_result_t due_results[$];   // results still owed by the block, oldest first
	int           mismatch_count;
	bit           quiet;            // set to run a phase with no idling on either side
	logic [31:0]  now_ticks;        // running notion of present time for well-formed traffic

	// Clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Watchdog: generous against the slowest legal run (every result stalled at length)
	initial begin
		#30ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Expiry is now plus linger, pinned at the top of the time range
	function automatic logic [31:0] expiry_from(logic [31:0] t);
		logic [32:0] sum;
		sum = {1'b0, t} + {17'b0, cur_linger};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// A key only matches a live slot with room, column and row all equal
	function automatic int find_mark(logic [9:0] rm, logic [7:0] cx, logic [7:0] cy);
		int i;
		for (i = 0; i < CAPACITY_DEF; i++)
			if (mark_valid[i] && mark_room[i] == rm && mark_col[i] == cx && mark_row[i] == cy)
				return i;
		return -1;
	endfunction

	function automatic mark_result_t make_result(logic [3:0] st, logic [9:0] rm,
			logic [7:0] cx, logic [7:0] cy, logic lst);
		mark_result_t r;
		r.status = st;
		r.room   = rm;
		r.x      = cx;
		r.y      = cy;
		r.last   = lst;
		return r;
	endfunction

	// Apply one accepted request word to the table copy and queue the results it owes
	function automatic void apply_to_table(logic [1:0] cmd, logic [9:0] rm, logic [7:0] cx,
			logic [7:0] cy, logic [31:0] t);
		int i;
		int slot;
		int removed;
		slot    = -1;
		removed = 0;
		case (cmd)
			CMD_ADD: begin
				if (rm >= cur_room_count || cx >= cur_width || cy >= cur_height) begin
					due_results.push_back(make_result(ST_REJECTED, rm, cx, cy, 1'b1));
				end else begin
					slot = find_mark(rm, cx, cy);
					if (slot >= 0) begin
						mark_expiry[slot] = expiry_from(t);
						due_results.push_back(make_result(ST_REFRESHED, rm, cx, cy, 1'b1));
					end else begin
						// New key goes into the lowest free slot, if there is one
						for (i = CAPACITY_DEF - 1; i >= 0; i--)
							if (!mark_valid[i])
								slot = i;
						if (slot < 0) begin
							due_results.push_back(make_result(ST_FULL, rm, cx, cy, 1'b1));
						end else begin
							mark_valid[slot]  = 1'b1;
							mark_room[slot]   = rm;
							mark_col[slot]    = cx;
							mark_row[slot]    = cy;
							mark_expiry[slot] = expiry_from(t);
							due_results.push_back(make_result(ST_CREATED, rm, cx, cy, 1'b1));
						end
					end
				end
			end
			CMD_QUERY: begin
				// Only the room is range-checked; column and row are not checked against the room size
				if (rm < cur_room_count && find_mark(rm, cx, cy) >= 0)
					due_results.push_back(make_result(ST_PRESENT, rm, cx, cy, 1'b1));
				else
					due_results.push_back(make_result(ST_ABSENT, rm, cx, cy, 1'b1));
			end
			CMD_SWEEP: begin
				// Slot order, whatever the room count; cap removals so the done word still fits
				for (i = 0; i < CAPACITY_DEF; i++) begin
					if (removed < MAX_OUT - 1 && mark_valid[i] && mark_expiry[i] <= t) begin
						mark_valid[i] = 1'b0;
						due_results.push_back(make_result(ST_REMOVED, mark_room[i], mark_col[i],
							mark_row[i], 1'b0));
						removed++;
					end
				end
				due_results.push_back(make_result(ST_DONE, '0, '0, '0, 1'b1));
			end
			CMD_CLEAR: begin
				for (i = 0; i < CAPACITY_DEF; i++)
					mark_valid[i] = 1'b0;
				due_results.push_back(make_result(ST_CLEARED, '0, '0, '0, 1'b1));
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Mostly back-to-back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(16, 40);
	endfunction

	// Offer one request word and hold it until taken; valid is left high so that a
	// following word can go out back to back without dropping it in between
	task automatic send_word(logic [1:0] cmd, logic [9:0] rm, logic [7:0] cx, logic [7:0] cy,
			logic [31:0] t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= cmd;
		req_ch.room         <= rm;
		req_ch.x            <= cx;
		req_ch.y            <= cy;
		req_ch.current_time <= t;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		apply_to_table(cmd, rm, cx, cy, t);
	endtask

	// Drop the request line and wait for every owed result to come back
	task automatic await_idle();
		req_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			REG_ROOM_COUNT:   cur_room_count = value[9:0];
			REG_ROOM_WIDTH:   cur_width      = value[7:0];
			REG_ROOM_HEIGHT:  cur_height     = value[7:0];
			REG_LINGER_TICKS: cur_linger     = value;
			default: ;
		endcase
	endtask

	// Only ever called with the block idle
	task automatic set_regs(int rc, int w, int h, int linger);
		write_reg(REG_ROOM_COUNT, CFG_DATA_W'(rc));
		write_reg(REG_ROOM_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_ROOM_HEIGHT, CFG_DATA_W'(h));
		write_reg(REG_LINGER_TICKS, CFG_DATA_W'(linger));
		cfg_ch.valid <= 1'b0;
	endtask

	// Half the time pick from the first few values so keys repeat and refreshes happen
	function automatic int pick_index(int span);
		if (span <= 0)
			return 0;
		if ($urandom_range(0, 1))
			return $urandom_range(0, (span < 4 ? span : 4) - 1);
		return $urandom_range(0, span - 1);
	endfunction

	// ------------------------------------------------------------------
	// Result checker and consumer stalls
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, mark_result_t want, mark_result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s: expected status %0d room %0d x %0d y %0d last %0b, got status %0d room %0d x %0d y %0d last %0b",
				$realtime, what, want.status, want.room, want.x, want.y, want.last,
				got.status, got.room, got.x, got.y, got.last);
	endtask

	initial begin : result_monitor
		int           run_left;
		mark_result_t got;
		mark_result_t want;
		run_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = make_result(rsp_ch.status, rsp_ch.room_res, rsp_ch.x_res, rsp_ch.y_res,
					rsp_ch.last);
				if (due_results.size() == 0) begin
					report_mismatch("result with nothing owed", '0, got);
				end else begin
					want = due_results.pop_front();
					if (got.status !== want.status || got.room !== want.room ||
							got.x !== want.x || got.y !== want.y || got.last !== want.last)
						report_mismatch("result mismatch", want, got);
				end
			end
			// Ready alternates between runs of acceptance and stalls of random length
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (quiet) begin
				rsp_ch.ready <= 1'b1;
				run_left = 0;
			end else if (run_left > 0) begin
				run_left--;
			end else if (rsp_ch.ready) begin
				rsp_ch.ready <= 1'b0;
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
			end else begin
				rsp_ch.ready <= 1'b1;
				run_left = $urandom_range(0, 15);
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: room count zero, so every add is turned away
	task automatic test_reset_defaults();
		send_word(CMD_ADD, 10'd0, 8'd0, 8'd0, 32'd5);
		send_word(CMD_QUERY, 10'd0, 8'd0, 8'd0, 32'd5);
		send_word(CMD_SWEEP, 10'd0, 8'd0, 8'd0, 32'hFFFF_FFFF);
		send_word(CMD_CLEAR, 10'd0, 8'd0, 8'd0, 32'd0);
		await_idle();
	endtask

	// Field extremes, range checks on each key part, partial key matches and saturation
	task automatic test_key_extremes();
		set_regs(1023, 255, 255, 65535);
		send_word(CMD_ADD, 10'd1022, 8'd254, 8'd254, 32'hFFFF_FFF0);   // expiry pins at max
		send_word(CMD_ADD, 10'd1023, 8'd0, 8'd0, 32'd0);
		send_word(CMD_ADD, 10'd0, 8'd255, 8'd0, 32'd0);
		send_word(CMD_ADD, 10'd0, 8'd0, 8'd255, 32'd0);
		send_word(CMD_ADD, 10'd0, 8'd0, 8'd0, 32'd0);
		send_word(CMD_ADD, 10'd0, 8'd0, 8'd0, 32'd1);                  // refresh
		send_word(CMD_QUERY, 10'd0, 8'd0, 8'd0, 32'd1);
		send_word(CMD_QUERY, 10'd0, 8'd0, 8'd1, 32'd1);
		send_word(CMD_QUERY, 10'd1, 8'd0, 8'd0, 32'd1);
		send_word(CMD_QUERY, 10'd1023, 8'd255, 8'd255, 32'd1);
		send_word(CMD_SWEEP, 10'd0, 8'd0, 8'd0, 32'd65535);            // one tick short
		send_word(CMD_SWEEP, 10'd1023, 8'd255, 8'd255, 32'hFFFF_FFFE);
		send_word(CMD_SWEEP, 10'd0, 8'd0, 8'd0, 32'hFFFF_FFFF);        // saturated mark goes
		send_word(CMD_CLEAR, 10'd1023, 8'd255, 8'd255, 32'hFFFF_FFFF);
		await_idle();
	endtask

	// Zero linger, expiry equal to now, and marks kept after the room count drops
	task automatic test_expiry_edges();
		set_regs(10, 8, 8, 0);
		send_word(CMD_ADD, 10'd9, 8'd7, 8'd7, 32'd500);
		send_word(CMD_ADD, 10'd2, 8'd3, 8'd4, 32'd600);
		await_idle();
		set_regs(5, 8, 8, 0);
		send_word(CMD_QUERY, 10'd9, 8'd7, 8'd7, 32'd600);
		send_word(CMD_QUERY, 10'd2, 8'd3, 8'd4, 32'd600);
		send_word(CMD_SWEEP, 10'd0, 8'd0, 8'd0, 32'd499);
		send_word(CMD_SWEEP, 10'd0, 8'd0, 8'd0, 32'd600);
		await_idle();
	endtask

	// Fill every slot, overflow it, then sweep past the removal cap and reuse freed slots
	task automatic test_table_full();
		int         i;
		logic [9:0] keep_room;
		logic [7:0] keep_x;
		logic [7:0] keep_y;
		logic [9:0] rm;
		logic [7:0] cx;
		logic [7:0] cy;
		set_regs(1023, 255, 255, 40);
		quiet = 1'b1;
		send_word(CMD_CLEAR, 10'd0, 8'd0, 8'd0, 32'd0);
		// Rooms i*16 + 0..14 keep every key distinct; rooms ending in 15 stay unused
		for (i = 0; i < CAPACITY_DEF; i++) begin
			rm = 10'(i * 16 + $urandom_range(0, 14));
			cx = 8'($urandom_range(0, 254));
			cy = 8'($urandom_range(0, 254));
			if (i == 5) begin
				keep_room = rm;
				keep_x    = cx;
				keep_y    = cy;
			end
			send_word(CMD_ADD, rm, cx, cy, 32'd1000);
		end
		quiet = 1'b0;
		send_word(CMD_ADD, 10'd15, 8'($urandom_range(0, 254)), 8'd9, 32'd1000);
		send_word(CMD_ADD, keep_room, keep_x, keep_y, 32'd1000);
		send_word(CMD_QUERY, keep_room, keep_x, keep_y, 32'd1000);
		send_word(CMD_SWEEP, 10'd0, 8'd0, 8'd0, 32'd1039);
		send_word(CMD_SWEEP, 10'd0, 8'd0, 8'd0, 32'd1040);
		send_word(CMD_ADD, 10'd31, 8'd1, 8'd2, 32'd2000);
		send_word(CMD_ADD, 10'd47, 8'd3, 8'd4, 32'd2000);
		send_word(CMD_SWEEP, 10'd0, 8'd0, 8'd0, 32'd5000);
		send_word(CMD_QUERY, 10'd31, 8'd1, 8'd2, 32'd5000);
		await_idle();
	endtask

	// Mostly well-formed traffic on a small key set, with some raw noise words mixed in
	task automatic test_random_mix(int items, int rc, int w, int h, int linger,
			logic [31:0] start);
		int         k;
		int         pick;
		logic [9:0] rm;
		logic [7:0] cx;
		logic [7:0] cy;
		await_idle();
		set_regs(rc, w, h, linger);
		now_ticks = start;
		for (k = 0; k < items; k++) begin
			now_ticks = now_ticks + $urandom_range(0, linger / 8 + 4);
			rm   = 10'(pick_index(rc));
			cx   = 8'(pick_index(w));
			cy   = 8'(pick_index(h));
			pick = $urandom_range(0, 99);
			if (pick < 45)
				send_word(CMD_ADD, rm, cx, cy, now_ticks);
			else if (pick < 65)
				send_word(CMD_QUERY, rm, cx, cy, now_ticks);
			else if (pick < 78)
				send_word(CMD_SWEEP, 10'($urandom), 8'($urandom), 8'($urandom), now_ticks);
			else if (pick < 81)
				send_word(CMD_CLEAR, 10'($urandom), 8'($urandom), 8'($urandom), now_ticks);
			else
				send_word(2'($urandom), 10'($urandom), 8'($urandom), 8'($urandom), $urandom);
		end
		await_idle();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin : run_tests
		int i;
		// Hold every input at a known value from the start
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.command      <= CMD_ADD;
		req_ch.room         <= '0;
		req_ch.x            <= '0;
		req_ch.y            <= '0;
		req_ch.current_time <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= REG_ROOM_COUNT;
		cfg_ch.data         <= '0;
		quiet          = 1'b0;
		mismatch_count = 0;
		now_ticks      = '0;
		for (i = 0; i < CAPACITY_DEF; i++)
			mark_valid[i] = 1'b0;
		cur_room_count = 10'd0;
		cur_width      = 8'd20;
		cur_height     = 8'd20;
		cur_linger     = 16'd100;

		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_key_extremes();
		test_expiry_edges();
		test_table_full();
		test_random_mix(36, 3, 4, 4, 20, 32'd0);
		test_random_mix(36, 1023, 255, 255, 65535, 32'hFFFF_0000);
		test_random_mix(30, 1, 1, 1, 0, $urandom);
		test_random_mix(36, $urandom_range(1, 1023), $urandom_range(1, 255),
			$urandom_range(1, 255), $urandom_range(0, 400), $urandom);
		quiet = 1'b1;
		test_random_mix(36, 8, 6, 6, 64, 32'd100);
		quiet = 1'b0;
		test_random_mix(12, 0, 255, 255, 1000, 32'd0);

		// Let any stray result surface before the verdict
		await_idle();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (mismatch_count == 0 && due_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/tsmt_pkg.sv
hdl/tsmt_intf.sv
hdl/tsmt_cell.sv
hdl/timed_square_mark_table.sv
verif/tb_timed_square_mark_table.sv
